>>> src/table_driven_fsm_engine_defines.svh
// Assertion macros for the table-driven FSM engine.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TABLE_DRIVEN_FSM_ENGINE_DEFINES_SVH
`define TABLE_DRIVEN_FSM_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

`define TDFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define TDFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TDFE_ASSERT_IMPL(lbl, ante, cons, msg)

`define TDFE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/tdfe_pkg.sv
`default_nettype none

package tdfe_pkg;

  localparam int MAX_STATES      = 16;
  localparam int MAX_TRANSITIONS = 64;
  localparam int NUM_GUARDS      = 16;

  localparam int STATE_W = $clog2(MAX_STATES);
  localparam int SLOT_W  = $clog2(MAX_TRANSITIONS);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int SCNT_W  = 5;

  // commands
  localparam logic [2:0] CMD_EVENT    = 3'd0;
  localparam logic [2:0] CMD_WR_DESC  = 3'd1;
  localparam logic [2:0] CMD_WR_TRANS = 3'd2;
  localparam logic [2:0] CMD_START    = 3'd3;
  localparam logic [2:0] CMD_STOP     = 3'd4;

  // result status
  localparam logic [2:0] STAT_DONE       = 3'd0;
  localparam logic [2:0] STAT_IGNORED    = 3'd1;
  localparam logic [2:0] STAT_NO_MATCH   = 3'd2;
  localparam logic [2:0] STAT_BLOCKED    = 3'd3;
  localparam logic [2:0] STAT_BAD_TARGET = 3'd4;
  localparam logic [2:0] STAT_REJECT     = 3'd5;

  // guard modes
  localparam logic [1:0] GM_NONE  = 2'd0;
  localparam logic [1:0] GM_TRUE  = 2'd1;
  localparam logic [1:0] GM_FALSE = 2'd2;
  localparam logic [1:0] GM_BAD   = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  event_code;
    logic [15:0] guard_bits;
    logic [5:0]  slot_index;
    logic [7:0]  state_value;
    logic [5:0]  trans_base;
    logic [6:0]  trans_count;
    logic [1:0]  state_action_flags;
    logic [3:0]  guard_index;
    logic [1:0]  guard_mode;
    logic        action_present;
    logic [7:0]  action_code;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       transitioned;
    logic [3:0] old_state;
    logic [3:0] new_state;
    logic       exit_fire;
    logic       entry_fire;
    logic       action_fire;
    logic [7:0] fired_action;
  } result_t;

  // state descriptor, bit1 of flags = exit action, bit0 = entry action
  typedef struct packed {
    logic [SLOT_W-1:0] base;
    logic [CNT_W-1:0]  count;
    logic [1:0]        flags;
  } desc_t;

  typedef struct packed {
    logic [7:0] ev_code;
    logic [7:0] target;
    logic [3:0] gidx;
    logic [1:0] gmode;
    logic       has_act;
    logic [7:0] act;
  } trans_t;

  typedef struct packed {
    logic               we;
    logic [STATE_W-1:0] addr;
    desc_t              data;
  } desc_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    trans_t            data;
  } trans_wr_t;

endpackage

`default_nettype wire

>>> src/tdfe_desc_ram.sv
`default_nettype none

module tdfe_desc_ram (
  input  wire                           clk,
  input  wire                           rst,
  input  tdfe_pkg::desc_wr_t            wr,
  input  wire  [tdfe_pkg::STATE_W-1:0]  raddr,
  output tdfe_pkg::desc_t               rdata
);
  import tdfe_pkg::*;

  desc_t           mem [MAX_STATES];
  desc_t           rd_q;
  logic [MAX_STATES-1:0] valid;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  // entries never written read as an empty descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

>>> src/tdfe_trans_ram.sv
`default_nettype none

module tdfe_trans_ram (
  input  wire                          clk,
  input  tdfe_pkg::trans_wr_t          wr,
  input  wire  [tdfe_pkg::SLOT_W-1:0]  raddr,
  output tdfe_pkg::trans_t             rdata
);
  import tdfe_pkg::*;

  trans_t mem [MAX_TRANSITIONS];
  trans_t rd_q;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  assign rdata = rd_q;

endmodule

`default_nettype wire

>>> src/tdfe_seq.sv
`default_nettype none
`include "table_driven_fsm_engine_defines.svh"

module tdfe_seq (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  tdfe_pkg::item_t               item,
  input  wire  [tdfe_pkg::SCNT_W-1:0]   nvalid,
  output tdfe_pkg::desc_wr_t            desc_wr,
  output logic [tdfe_pkg::STATE_W-1:0]  desc_raddr,
  input  tdfe_pkg::desc_t               desc_rdata,
  output tdfe_pkg::trans_wr_t           trans_wr,
  output logic [tdfe_pkg::SLOT_W-1:0]   trans_raddr,
  input  tdfe_pkg::trans_t              trans_rdata,
  output logic                          done,
  output tdfe_pkg::result_t             result
);
  import tdfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DESC  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_ENTRY = 4'b1000
  } seq_state_t;

  seq_state_t            st;
  logic                  active;
  logic [STATE_W-1:0]    cur_state;
  logic [7:0]            ev_q;
  logic [NUM_GUARDS-1:0] gbits_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [CNT_W-1:0]      rem;
  logic                  exit_flag;
  logic                  matched;
  logic [STATE_W-1:0]    hit_tgt;
  logic                  hit_act_p;
  logic [7:0]            hit_act;

  logic acc;
  logic ev_ok;
  logic desc_ok;
  logic trans_ok;
  logic start_ok;
  logic start_take;
  logic ev_match;
  logic tgt_bad;
  logic gbit;
  logic pass;
  logic last;

  assign busy = (st != S_IDLE);
  assign acc  = start && (st == S_IDLE);

  assign ev_ok    = (item.event_code != 8'd0) && active
                 && ({1'b0, cur_state} < nvalid);
  assign desc_ok  = (item.slot_index < 6'(MAX_STATES))
                 && (({2'b00, item.trans_base} + {1'b0, item.trans_count})
                     <= 8'(MAX_TRANSITIONS));
  assign trans_ok = ({1'b0, item.slot_index} < 7'(MAX_TRANSITIONS))
                 && (item.guard_mode != GM_BAD)
                 && ({1'b0, item.guard_index} < 5'(NUM_GUARDS));
  assign start_ok = item.state_value < {3'b000, nvalid};
  // start that actually moves the machine: inactive machine and a valid state
  assign start_take = (item.command == CMD_START) && !active && start_ok;

  // evaluation of the slot whose entry arrives this cycle
  assign ev_match = (trans_rdata.ev_code == ev_q);
  assign tgt_bad  = trans_rdata.target >= {3'b000, nvalid};
  assign gbit     = gbits_q[trans_rdata.gidx];
  assign pass     = (trans_rdata.gmode == GM_NONE)
                 || ((trans_rdata.gmode == GM_TRUE) && gbit)
                 || ((trans_rdata.gmode == GM_FALSE) && !gbit);
  assign last     = (rem == CNT_W'(1)) || (slot_q == {SLOT_W{1'b1}});

  always_comb begin
    desc_wr.we         = acc && (item.command == CMD_WR_DESC) && desc_ok;
    desc_wr.addr       = item.slot_index[STATE_W-1:0];
    desc_wr.data.base  = item.trans_base;
    desc_wr.data.count = item.trans_count;
    desc_wr.data.flags = item.state_action_flags;

    trans_wr.we           = acc && (item.command == CMD_WR_TRANS) && trans_ok;
    trans_wr.addr         = item.slot_index[SLOT_W-1:0];
    trans_wr.data.ev_code = item.event_code;
    trans_wr.data.target  = item.state_value;
    trans_wr.data.gidx    = item.guard_index;
    trans_wr.data.gmode   = item.guard_mode;
    trans_wr.data.has_act = item.action_present;
    trans_wr.data.act     = item.action_code;

    // current state's descriptor on accept, target's descriptor on a hit
    desc_raddr  = (st == S_SCAN) ? trans_rdata.target[STATE_W-1:0] : cur_state;
    // slots are fetched one ahead of the check
    trans_raddr = (st == S_DESC) ? desc_rdata.base : slot_q + SLOT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      active    <= 1'b0;
      cur_state <= '0;
      done      <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (start) begin
            ev_q                <= item.event_code;
            gbits_q             <= item.guard_bits;
            result.transitioned <= 1'b0;
            result.old_state    <= cur_state;
            result.new_state    <= start_take ? item.state_value[STATE_W-1:0] : cur_state;
            result.exit_fire    <= 1'b0;
            result.entry_fire   <= 1'b0;
            result.action_fire  <= 1'b0;
            result.fired_action <= 8'd0;
            case (item.command)
              CMD_EVENT: begin
                result.status <= STAT_IGNORED;
                done          <= !ev_ok;
                if (ev_ok) begin
                  st <= S_DESC;
                end
              end
              CMD_WR_DESC: begin
                result.status <= desc_ok ? STAT_DONE : STAT_REJECT;
                done          <= 1'b1;
              end
              CMD_WR_TRANS: begin
                result.status <= trans_ok ? STAT_DONE : STAT_REJECT;
                done          <= 1'b1;
              end
              CMD_START: begin
                if (start_take) begin
                  cur_state     <= item.state_value[STATE_W-1:0];
                  active        <= 1'b1;
                  result.status <= STAT_DONE;
                end else if (active) begin
                  result.status <= STAT_IGNORED;
                end else begin
                  result.status <= STAT_REJECT;
                end
                done <= 1'b1;
              end
              CMD_STOP: begin
                active        <= 1'b0;
                result.status <= STAT_DONE;
                done          <= 1'b1;
              end
              default: begin
                result.status <= STAT_IGNORED;
                done          <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_DESC: begin
          slot_q    <= desc_rdata.base;
          rem       <= desc_rdata.count;
          exit_flag <= desc_rdata.flags[1];
          matched   <= 1'b0;
          done      <= (desc_rdata.count == '0);
          if (desc_rdata.count == '0) begin
            result.status <= STAT_NO_MATCH;
            st            <= S_IDLE;
          end else begin
            st <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ev_match && tgt_bad) begin
            result.status <= STAT_BAD_TARGET;
            done          <= 1'b1;
            st            <= S_IDLE;
          end else if (ev_match && pass) begin
            hit_tgt   <= trans_rdata.target[STATE_W-1:0];
            hit_act_p <= trans_rdata.has_act;
            hit_act   <= trans_rdata.act;
            if (trans_rdata.target[STATE_W-1:0] != cur_state) begin
              done <= 1'b0;
              st   <= S_ENTRY;
            end else begin
              // self transition: no exit or entry
              result.status       <= STAT_DONE;
              result.transitioned <= 1'b1;
              result.action_fire  <= trans_rdata.has_act;
              result.fired_action <= trans_rdata.has_act ? trans_rdata.act : 8'd0;
              done                <= 1'b1;
              st                  <= S_IDLE;
            end
          end else begin
            if (ev_match) begin
              matched <= 1'b1;
            end
            if (last) begin
              result.status <= (matched || ev_match) ? STAT_BLOCKED : STAT_NO_MATCH;
              done          <= 1'b1;
              st            <= S_IDLE;
            end else begin
              slot_q <= slot_q + SLOT_W'(1);
              rem    <= rem - CNT_W'(1);
              done   <= 1'b0;
            end
          end
        end
        S_ENTRY: begin
          cur_state           <= hit_tgt;
          result.status       <= STAT_DONE;
          result.transitioned <= 1'b1;
          result.new_state    <= hit_tgt;
          result.exit_fire    <= exit_flag;
          result.entry_fire   <= desc_rdata.flags[0];
          result.action_fire  <= hit_act_p;
          result.fired_action <= hit_act_p ? hit_act : 8'd0;
          done                <= 1'b1;
          st                  <= S_IDLE;
        end
        default: begin
          done <= 1'b0;
          st   <= S_IDLE;
        end
      endcase
    end
  end

  `TDFE_ASSERT_NEXT(a_accept_progress, acc, done || (st != S_IDLE), "accepted item stalled")
  `TDFE_ASSERT_IMPL(a_scan_count, st == S_SCAN, rem != '0, "scan with no slots left")
  `TDFE_ASSERT_IMPL(a_took_done, done && result.transitioned, result.status == STAT_DONE, "transition with bad status")
  `TDFE_ASSERT_IMPL(a_no_take_quiet, done && !result.transitioned, !result.exit_fire && !result.entry_fire && !result.action_fire && (result.fired_action == 8'd0), "action fired without transition")
  `TDFE_ASSERT_IMPL(a_change_fire, done && (result.exit_fire || result.entry_fire), result.old_state != result.new_state, "exit or entry without state change")

endmodule

`default_nettype wire

>>> src/table_driven_fsm_engine.sv
// Table-driven state machine engine; results cannot be stalled by the receiver.
// Writes, start, stop and ignored events give their result in the cycle after accept.
// An event reads the current state's descriptor, then scans its n slots (0..64), then,
// when the state changes, reads the target descriptor; busy stays high and clears as done rises.
// Throughput: one item at a time, one transition slot per cycle from the slot memory.
// Reset (rst, sync): machine inactive, state 0, descriptors empty, state_count 16.
`default_nettype none

module table_driven_fsm_engine (
  input  wire                                 clk,
  input  wire                                 rst,
  // command channel
  input  wire                                 start,
  output logic                                busy,
  input  tdfe_pkg::item_t                     item,
  // result strobe, one cycle per item
  output logic                                done,
  output tdfe_pkg::result_t                   result,
  // state_count register write
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [tdfe_pkg::SCNT_W-1:0]         cfg_data
);
  import tdfe_pkg::*;

  logic [SCNT_W-1:0]  state_count;
  logic [SCNT_W-1:0]  nvalid;

  desc_wr_t           desc_wr;
  logic [STATE_W-1:0] desc_raddr;
  desc_t              desc_rdata;
  trans_wr_t          trans_wr;
  logic [SLOT_W-1:0]  trans_raddr;
  trans_t             trans_rdata;

  // config is only taken between items, never on the edge that takes an item
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= SCNT_W'(MAX_STATES);
    end else if (cfg_valid && cfg_ready) begin
      state_count <= cfg_data;
    end
  end

  // valid states: state_count saturated at the table depth
  assign nvalid = (state_count > SCNT_W'(MAX_STATES)) ? SCNT_W'(MAX_STATES) : state_count;

  // descriptors: 16 entries, valid bits give the cleared-at-reset view
  tdfe_desc_ram u_desc (
    .clk   (clk),
    .rst   (rst),
    .wr    (desc_wr),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  // transition slots: contents undefined until written
  tdfe_trans_ram u_trans (
    .clk   (clk),
    .wr    (trans_wr),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  // sequencer: command decode, slot scan, result register
  tdfe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .nvalid      (nvalid),
    .desc_wr     (desc_wr),
    .desc_raddr  (desc_raddr),
    .desc_rdata  (desc_rdata),
    .trans_wr    (trans_wr),
    .trans_raddr (trans_raddr),
    .trans_rdata (trans_rdata),
    .done        (done),
    .result      (result)
  );

endmodule

`default_nettype wire
